// ===== hw/rtl/cpt_pkg.sv =====
// Shared constants, types and arithmetic helpers for the Clarke/Park transform unit.
// No dependencies; every other file in hw/rtl imports this package.
package cpt_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ANGLE_W     = 16;
  localparam int SINE_DEPTH  = 1024;
  localparam int QTR_W       = ANGLE_W - 2;
  localparam int IDX_W       = $clog2(SINE_DEPTH + 1);
  localparam int TAB_W       = 16;
  localparam int TRIG_W      = TAB_W + 1;
  localparam int MID_W       = 18;
  localparam int COEF_W      = 18;
  localparam int PROD_W      = 36;
  localparam int SUM_W       = 38;
  localparam int FIN_W       = 20;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ABC_TO_AB0 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AB0_TO_ABC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AB0_TO_DQ0 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DQ0_TO_AB0 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ABC_TO_DQ0 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DQ0_TO_ABC = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME   = 1'b1;

  // Rounding shifts
  localparam logic [4:0] SH_CLARKE_A = 5'd17;
  localparam logic [4:0] SH_UNIT     = 5'd16;
  localparam logic [4:0] SH_TRIG     = 5'd15;

  // Q1.16 coefficients
  localparam logic signed [COEF_W-1:0] K_R23  = 18'sd53510;
  localparam logic signed [COEF_W-1:0] K_R12  = 18'sd46341;
  localparam logic signed [COEF_W-1:0] K_R16  = 18'sd26755;
  localparam logic signed [COEF_W-1:0] K_R13  = 18'sd37837;
  localparam logic signed [COEF_W-1:0] K_23   = 18'sd43691;
  localparam logic signed [COEF_W-1:0] K_13   = 18'sd21845;
  localparam logic signed [COEF_W-1:0] K_S32  = 18'sd56756;
  localparam logic signed [COEF_W-1:0] K_HALF = 18'sd32768;
  localparam logic signed [COEF_W-1:0] K_ONE  = 18'sd65536;

  localparam int SMAX = (2 ** (SAMPLE_W - 1)) - 1;
  localparam int SMIN = -(2 ** (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SMAX);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(SMIN);

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic signed [MID_W-1:0]  mid_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [FIN_W-1:0]  fin_t;
  typedef logic [TAB_W-1:0] sine_tab_t [SINE_DEPTH+1];

  typedef struct packed {
    logic                       clip;
    logic signed [SAMPLE_W-1:0] val;
  } sat_t;

  // Quarter-wave sine table, Q30 Taylor series, evaluated at elaboration.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = (PI_HALF_Q30 * 64'(i)) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
      if (r > 64'd32768) r = 64'd32768;
      tab[i] = TAB_W'(r);
    end
    return tab;
  endfunction

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic sum_t rnd_half_up(input sum_t v, input logic [4:0] sh);
    sum_t w;
    w = v + (sum_t'(1) <<< (sh - 5'd1));
    return w >>> sh;
  endfunction

  function automatic sat_t saturate(input fin_t v);
    sat_t r;
    if (v > fin_t'(SMAX)) begin
      r.clip = 1'b1;
      r.val  = SAMPLE_MAX;
    end else if (v < fin_t'(SMIN)) begin
      r.clip = 1'b1;
      r.val  = SAMPLE_MIN;
    end else begin
      r.clip = 1'b0;
      r.val  = SAMPLE_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cpt_in_if.sv =====
// Input channel of the transform unit: valid/ready plus mode, samples and angle.
// Depends on cpt_pkg.
interface cpt_in_if import cpt_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [SAMPLE_W-1:0] in_x;
  logic signed [SAMPLE_W-1:0] in_y;
  logic signed [SAMPLE_W-1:0] in_z;
  logic [ANGLE_W-1:0]         angle;

  modport source (output valid, mode, in_x, in_y, in_z, angle, input ready);
  modport sink   (input valid, mode, in_x, in_y, in_z, angle, output ready);
endinterface

// ===== hw/rtl/cpt_out_if.sv =====
// Result channel of the transform unit: valid/ready plus three samples and a clip flag.
// Depends on cpt_pkg.
interface cpt_out_if import cpt_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_x;
  logic signed [SAMPLE_W-1:0] out_y;
  logic signed [SAMPLE_W-1:0] out_z;
  logic                       saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== hw/rtl/cpt_sincos.sv =====
// Sine/cosine lookup: quarter-wave ROM with two registered read ports.
// Depends on cpt_pkg.
module cpt_sincos import cpt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ANGLE_W-1:0]       angle_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam sine_tab_t SINE_ROM = build_sine();
  localparam int SC_W = QTR_W + IDX_W + 1;

  // Return {negate, table index}.
  function automatic logic [IDX_W:0] trig_addr(input logic [ANGLE_W-1:0] a);
    logic [1:0]       quad;
    logic [QTR_W:0]   p;
    logic [SC_W-1:0]  sc;
    logic [SC_W-1:0]  sh;
    logic [IDX_W-1:0] idx;
    quad = a[ANGLE_W-1 -: 2];
    p    = {1'b0, a[QTR_W-1:0]};
    if (quad[0]) p = (QTR_W + 1)'(2 ** QTR_W) - p;
    sc = SC_W'(p) * SC_W'(SINE_DEPTH);
    sh = sc >> QTR_W;
    if (sh > SC_W'(SINE_DEPTH)) idx = IDX_W'(SINE_DEPTH);
    else idx = sh[IDX_W-1:0];
    return {quad[1], idx};
  endfunction

  logic [IDX_W:0]     sin_a;
  logic [IDX_W:0]     cos_a;
  logic [TAB_W-1:0]   sin_mag_q;
  logic [TAB_W-1:0]   cos_mag_q;
  logic               sin_neg_q;
  logic               cos_neg_q;

  assign sin_a = trig_addr(angle_i);
  assign cos_a = trig_addr(angle_i + ANGLE_W'(2 ** QTR_W));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_q <= SINE_ROM[sin_a[IDX_W-1:0]];
      cos_mag_q <= SINE_ROM[cos_a[IDX_W-1:0]];
      sin_neg_q <= sin_a[IDX_W];
      cos_neg_q <= cos_a[IDX_W];
    end
  end

  assign sin_o = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
  assign cos_o = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});

endmodule

// ===== hw/rtl/cpt_clarke_fwd.sv =====
// Forward Clarke multipliers: abc to scaled alpha/beta/zero products.
// Depends on cpt_pkg.
module cpt_clarke_fwd import cpt_pkg::*; (
  input  logic                       scale_i,
  input  logic signed [SAMPLE_W-1:0] a_i,
  input  logic signed [SAMPLE_W-1:0] b_i,
  input  logic signed [SAMPLE_W-1:0] c_i,
  output prod_t                      p_alpha_o,
  output prod_t                      p_beta_o,
  output prod_t                      p_zero_o
);

  mid_t d2;
  mid_t bc;
  mid_t sm;
  logic signed [COEF_W-1:0] ka;
  logic signed [COEF_W-1:0] kb;
  logic signed [COEF_W-1:0] kz;

  assign d2 = (MID_W'(a_i) <<< 1) - MID_W'(b_i) - MID_W'(c_i);
  assign bc = MID_W'(b_i) - MID_W'(c_i);
  assign sm = MID_W'(a_i) + MID_W'(b_i) + MID_W'(c_i);

  assign ka = scale_i ? K_23  : K_R23;
  assign kb = scale_i ? K_R13 : K_R12;
  assign kz = scale_i ? K_13  : K_R13;

  assign p_alpha_o = d2 * ka;
  assign p_beta_o  = bc * kb;
  assign p_zero_o  = sm * kz;

endmodule

// ===== hw/rtl/cpt_rotate.sv =====
// Park rotation multipliers: the four cross products of (alpha, beta) and (sin, cos).
// Depends on cpt_pkg.
module cpt_rotate import cpt_pkg::*; (
  input  mid_t                     al_i,
  input  mid_t                     be_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  output prod_t                    as_o,
  output prod_t                    ac_o,
  output prod_t                    bs_o,
  output prod_t                    bc_o
);

  assign as_o = PROD_W'(al_i) * PROD_W'(sin_i);
  assign ac_o = PROD_W'(al_i) * PROD_W'(cos_i);
  assign bs_o = PROD_W'(be_i) * PROD_W'(sin_i);
  assign bc_o = PROD_W'(be_i) * PROD_W'(cos_i);

endmodule

// ===== hw/rtl/cpt_clarke_inv.sv =====
// Inverse Clarke multipliers: alpha/beta/zero times the selected coefficient set.
// Depends on cpt_pkg.
module cpt_clarke_inv import cpt_pkg::*; (
  input  logic  scale_i,
  input  mid_t  al_i,
  input  mid_t  be_i,
  input  mid_t  ze_i,
  output prod_t pa0_o,
  output prod_t pa1_o,
  output prod_t pb_o,
  output prod_t pz_o
);

  logic signed [COEF_W-1:0] k0;
  logic signed [COEF_W-1:0] k1;
  logic signed [COEF_W-1:0] kb;
  logic signed [COEF_W-1:0] kz;

  assign k0 = scale_i ? K_ONE  : K_R23;
  assign k1 = scale_i ? K_HALF : K_R16;
  assign kb = scale_i ? K_S32  : K_R12;
  assign kz = scale_i ? K_ONE  : K_R13;

  assign pa0_o = al_i * k0;
  assign pa1_o = al_i * k1;
  assign pb_o  = be_i * kb;
  assign pz_o  = ze_i * kz;

endmodule

// ===== hw/rtl/clarke_park_transform_unit.sv =====
// Clarke/Park transform unit (abc <-> alpha-beta-zero <-> dq0), four-stage pipeline.
// Throughput 1 transaction/cycle while out_m.ready does not stall the pipeline, set by at most one
// multiplier rank per stage and the two-port sine ROM read in stage 1.
// Reset (rst_ni, async low) clears the stage valid bits and both config registers;
// the sine ROM is constant, so there is no clearing pass.
module clarke_park_transform_unit import cpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cpt_in_if.sink               in_s,
  cpt_out_if.source            out_m,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic scale_q;
  logic frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 1'b0;
      frame_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCALING: scale_q <= cfg_data_i;
        REG_FRAME:   frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_m.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_s.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_s.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the transaction, forward Clarke products, sine/cos lookup
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]          mode1_q;
  logic signed [SAMPLE_W-1:0] x1_q, y1_q, z1_q;
  prod_t                      cp_a, cp_b, cp_z;
  prod_t                      cp_a1_q, cp_b1_q, cp_z1_q;
  logic signed [TRIG_W-1:0]   sin1, cos1;

  cpt_clarke_fwd u_clarke_fwd (
    .scale_i   (scale_q),
    .a_i       (in_s.in_x),
    .b_i       (in_s.in_y),
    .c_i       (in_s.in_z),
    .p_alpha_o (cp_a),
    .p_beta_o  (cp_b),
    .p_zero_o  (cp_z)
  );

  // ROM data registers sit inside; they advance with stage 1.
  cpt_sincos u_sincos (
    .clk_i   (clk_i),
    .en_i    (en1),
    .angle_i (in_s.angle),
    .sin_o   (sin1),
    .cos_o   (cos1)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q <= in_s.mode;
      x1_q    <= in_s.in_x;
      y1_q    <= in_s.in_y;
      z1_q    <= in_s.in_z;
      cp_a1_q <= cp_a;
      cp_b1_q <= cp_b;
      cp_z1_q <= cp_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round Clarke result, pick the rotation input, rotation products
  // ---------------------------------------------------------------------------
  mid_t  cla [3];
  mid_t  rot_a, rot_b, rot_z;
  prod_t pr_as, pr_ac, pr_bs, pr_bc;

  assign cla[0] = MID_W'(rnd_half_up(SUM_W'(cp_a1_q), SH_CLARKE_A));
  assign cla[1] = MID_W'(rnd_half_up(SUM_W'(cp_b1_q), SH_UNIT));
  assign cla[2] = MID_W'(rnd_half_up(SUM_W'(cp_z1_q), SH_UNIT));

  // abc -> dq0 rotates the Clarke result; the other rotating modes take the inputs.
  always_comb begin
    if (mode1_q == MODE_ABC_TO_DQ0) begin
      rot_a = cla[0];
      rot_b = cla[1];
      rot_z = cla[2];
    end else begin
      rot_a = MID_W'(x1_q);
      rot_b = MID_W'(y1_q);
      rot_z = MID_W'(z1_q);
    end
  end

  cpt_rotate u_rotate (
    .al_i  (rot_a),
    .be_i  (rot_b),
    .sin_i (sin1),
    .cos_i (cos1),
    .as_o  (pr_as),
    .ac_o  (pr_ac),
    .bs_o  (pr_bs),
    .bc_o  (pr_bc)
  );

  logic [MODE_W-1:0]          mode2_q;
  logic signed [SAMPLE_W-1:0] x2_q, y2_q, z2_q;
  mid_t                       cla2_q [3];
  mid_t                       rz2_q;
  prod_t                      pr_as2_q, pr_ac2_q, pr_bs2_q, pr_bc2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mode2_q  <= mode1_q;
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      z2_q     <= z1_q;
      cla2_q   <= cla;
      rz2_q    <= rot_z;
      pr_as2_q <= pr_as;
      pr_ac2_q <= pr_ac;
      pr_bs2_q <= pr_bs;
      pr_bc2_q <= pr_bc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: combine and round the rotation, inverse Clarke products
  // ---------------------------------------------------------------------------
  logic  rot_fwd;
  sum_t  s_as, s_ac, s_bs, s_bc;
  sum_t  rs0, rs1;
  mid_t  pk [3];
  mid_t  ic_a, ic_b, ic_z;
  prod_t ip_a0, ip_a1, ip_b, ip_z;

  assign rot_fwd = (mode2_q == MODE_AB0_TO_DQ0) || (mode2_q == MODE_ABC_TO_DQ0);
  assign s_as = SUM_W'(pr_as2_q);
  assign s_ac = SUM_W'(pr_ac2_q);
  assign s_bs = SUM_W'(pr_bs2_q);
  assign s_bc = SUM_W'(pr_bc2_q);

  // Frame alignment moves the d axis between 90 degrees behind phase A and onto it.
  always_comb begin
    if (rot_fwd) begin
      if (!frame_q) begin
        rs0 = s_as - s_bc;
        rs1 = s_ac + s_bs;
      end else begin
        rs0 = s_ac + s_bs;
        rs1 = s_bc - s_as;
      end
    end else begin
      if (!frame_q) begin
        rs0 = s_as + s_bc;
        rs1 = s_bs - s_ac;
      end else begin
        rs0 = s_ac - s_bs;
        rs1 = s_as + s_bc;
      end
    end
  end

  assign pk[0] = MID_W'(rnd_half_up(rs0, SH_TRIG));
  assign pk[1] = MID_W'(rnd_half_up(rs1, SH_TRIG));
  assign pk[2] = rz2_q;  // zero component passes the rotation unchanged

  // dq0 -> abc feeds the inverse rotation into the inverse Clarke.
  always_comb begin
    if (mode2_q == MODE_DQ0_TO_ABC) begin
      ic_a = pk[0];
      ic_b = pk[1];
      ic_z = pk[2];
    end else begin
      ic_a = MID_W'(x2_q);
      ic_b = MID_W'(y2_q);
      ic_z = MID_W'(z2_q);
    end
  end

  cpt_clarke_inv u_clarke_inv (
    .scale_i (scale_q),
    .al_i    (ic_a),
    .be_i    (ic_b),
    .ze_i    (ic_z),
    .pa0_o   (ip_a0),
    .pa1_o   (ip_a1),
    .pb_o    (ip_b),
    .pz_o    (ip_z)
  );

  logic [MODE_W-1:0] mode3_q;
  mid_t              cla3_q [3];
  mid_t              pk3_q [3];
  prod_t             ip_a03_q, ip_a13_q, ip_b3_q, ip_z3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mode3_q  <= mode2_q;
      cla3_q   <= cla2_q;
      pk3_q    <= pk;
      ip_a03_q <= ip_a0;
      ip_a13_q <= ip_a1;
      ip_b3_q  <= ip_b;
      ip_z3_q  <= ip_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: inverse Clarke sums, result select, saturation, output register
  // ---------------------------------------------------------------------------
  sum_t s_a0, s_a1, s_b, s_z;
  fin_t ci [3];
  fin_t fin [3];
  sat_t sx, sy, sz;

  assign s_a0 = SUM_W'(ip_a03_q);
  assign s_a1 = SUM_W'(ip_a13_q);
  assign s_b  = SUM_W'(ip_b3_q);
  assign s_z  = SUM_W'(ip_z3_q);

  assign ci[0] = FIN_W'(rnd_half_up(s_a0 + s_z, SH_UNIT));
  assign ci[1] = FIN_W'(rnd_half_up(s_b - s_a1 + s_z, SH_UNIT));
  assign ci[2] = FIN_W'(rnd_half_up(s_z - s_a1 - s_b, SH_UNIT));

  always_comb begin
    case (mode3_q) inside
      MODE_ABC_TO_AB0: begin
        fin[0] = FIN_W'(cla3_q[0]);
        fin[1] = FIN_W'(cla3_q[1]);
        fin[2] = FIN_W'(cla3_q[2]);
      end
      MODE_AB0_TO_DQ0, MODE_DQ0_TO_AB0, MODE_ABC_TO_DQ0: begin
        fin[0] = FIN_W'(pk3_q[0]);
        fin[1] = FIN_W'(pk3_q[1]);
        fin[2] = FIN_W'(pk3_q[2]);
      end
      MODE_AB0_TO_ABC, MODE_DQ0_TO_ABC: begin
        fin = ci;
      end
      default: begin
        // unused operation codes return zeros
        fin[0] = '0;
        fin[1] = '0;
        fin[2] = '0;
      end
    endcase
  end

  assign sx = saturate(fin[0]);
  assign sy = saturate(fin[1]);
  assign sz = saturate(fin[2]);

  logic [MODE_W-1:0]          mode4_q;
  logic signed [SAMPLE_W-1:0] ox_q, oy_q, oz_q;
  logic                       osat_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      mode4_q <= mode3_q;
      ox_q    <= sx.val;
      oy_q    <= sy.val;
      oz_q    <= sz.val;
      osat_q  <= sx.clip | sy.clip | sz.clip;
    end
  end

  assign out_m.valid     = v4_q;
  assign out_m.out_x     = ox_q;
  assign out_m.out_y     = oy_q;
  assign out_m.out_z     = oz_q;
  assign out_m.saturated = osat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_unused_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && (mode4_q > MODE_DQ0_TO_ABC) |->
      (ox_q == '0) && (oy_q == '0) && (oz_q == '0) && !osat_q)
    else $error("unused operation code produced a nonzero result");

  a_clip_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && osat_q |->
      (ox_q == SAMPLE_MAX) || (ox_q == SAMPLE_MIN) ||
      (oy_q == SAMPLE_MAX) || (oy_q == SAMPLE_MIN) ||
      (oz_q == SAMPLE_MAX) || (oz_q == SAMPLE_MIN))
    else $error("saturation flag set with no output on a rail");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !en3 |=> v3_q)
    else $error("stage 3 dropped a transaction while stalled");

endmodule

// ===== tb/tb_clarke_park_transform_unit.sv =====
// Self-checking testbench for clarke_park_transform_unit: all six transforms and both
// settings of each config register, with random idling on both channels.
// Depends on cpt_pkg, cpt_in_if, cpt_out_if and the RTL top level.
`timescale 1ns / 100ps

module tb_clarke_park_transform_unit;
  import cpt_pkg::*;

  // Codes the package leaves unnamed: the two spare modes.
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int  STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int  DRAIN_WAIT  = 8;     // pipeline is 4 deep; allow some margin
  localparam int  RAND_ITEMS  = 75;    // per config phase
  localparam longint PI_HALF_Q30_L = 64'd1686629713;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic [ANGLE_W-1:0]         angle;
  } xform_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic                       sat;
  } xform_res_t;

  // Queue of predicted results in acceptance order; checks each result against the oldest.
  class xform_scoreboard;
    xform_res_t pending[$];
    int         errors = 0;

    function void note(xform_res_t e);
      pending.push_back(e);
    endfunction

    function void check(xform_res_t a);
      xform_res_t e;
      if (pending.size() == 0) begin
        $error("result with no pending transaction: x=%0d y=%0d z=%0d", a.x, a.y, a.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin
        $error("out_x mismatch: expected %0d, actual %0d", e.x, a.x);
        errors++;
      end
      if (a.y !== e.y) begin
        $error("out_y mismatch: expected %0d, actual %0d", e.y, a.y);
        errors++;
      end
      if (a.z !== e.z) begin
        $error("out_z mismatch: expected %0d, actual %0d", e.z, a.z);
        errors++;
      end
      if (a.sat !== e.sat) begin
        $error("saturated mismatch: expected %0b, actual %0b", e.sat, a.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic cfg_data_i;

  cpt_in_if  in_ch ();
  cpt_out_if out_ch ();

  clarke_park_transform_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_ch),
    .out_m      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  xform_scoreboard sb;

  // Predictor copy of the config registers.
  logic pwr_scale_n;   // scaling_select: 1 = amplitude invariant
  logic d_on_a;        // frame_align: 1 = d axis on phase A

  longint quarter_sine [SINE_DEPTH+1];

  bit drain_done;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fill the quarter-wave table with a 13-term Taylor series in Q30.
  function automatic void fill_sine();
    longint unsigned ph, ph2, tm, rr;
    longint acc;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      ph  = (PI_HALF_Q30_L * longint'(i)) / SINE_DEPTH;
      ph2 = (ph * ph) >> 30;
      tm  = ph;
      acc = longint'(ph);
      for (int k = 1; k <= 12; k++) begin
        tm = (tm * ph2) >> 30;
        tm = tm / longint'((2 * k) * (2 * k + 1));
        if (k % 2) acc -= longint'(tm);
        else acc += longint'(tm);
      end
      if (acc < 0) acc = 0;
      rr = (longint'(acc) * 32768 + (64'd1 << 29)) >> 30;
      if (rr > 32768) rr = 32768;
      quarter_sine[i] = longint'(rr);
    end
  endfunction

  function automatic longint sine_lookup(logic [ANGLE_W-1:0] ang);
    logic [1:0] quad;
    longint     ph, idx, v;
    quad = ang[ANGLE_W-1 -: 2];
    ph   = longint'(ang[QTR_W-1:0]);
    if (quad[0]) ph = (64'd1 << QTR_W) - ph;
    idx = (ph * SINE_DEPTH) >>> QTR_W;
    if (idx > SINE_DEPTH) idx = SINE_DEPTH;
    v = quarter_sine[idx];
    return quad[1] ? -v : v;
  endfunction

  // Round half toward +inf after dropping sh bits.
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic void to_ab0(longint a, longint b, longint c, output longint o[3]);
    longint d2, bc, s3;
    d2 = 2 * a - b - c;
    bc = b - c;
    s3 = a + b + c;
    if (!pwr_scale_n) begin
      o[0] = round_shift(d2 * 53510, 17);
      o[1] = round_shift(bc * 46341, 16);
      o[2] = round_shift(s3 * 37837, 16);
    end else begin
      o[0] = round_shift(d2 * 43691, 17);
      o[1] = round_shift(bc * 37837, 16);
      o[2] = round_shift(s3 * 21845, 16);
    end
  endfunction

  function automatic void to_abc(longint al, longint be, longint ze, output longint o[3]);
    if (!pwr_scale_n) begin
      o[0] = round_shift(al * 53510 + ze * 37837, 16);
      o[1] = round_shift(-al * 26755 + be * 46341 + ze * 37837, 16);
      o[2] = round_shift(-al * 26755 - be * 46341 + ze * 37837, 16);
    end else begin
      o[0] = round_shift(al * 65536 + ze * 65536, 16);
      o[1] = round_shift(-al * 32768 + be * 56756 + ze * 65536, 16);
      o[2] = round_shift(-al * 32768 - be * 56756 + ze * 65536, 16);
    end
  endfunction

  function automatic void rotate(bit inverse, longint u, longint v, longint ze,
                                 logic [ANGLE_W-1:0] ang, output longint o[3]);
    longint sn, cs;
    sn = sine_lookup(ang);
    cs = sine_lookup(ang + ANGLE_W'(1 << QTR_W));
    if (!inverse && !d_on_a) begin
      o[0] = round_shift(u * sn - v * cs, 15);
      o[1] = round_shift(u * cs + v * sn, 15);
    end else if (!inverse) begin
      o[0] = round_shift(u * cs + v * sn, 15);
      o[1] = round_shift(-u * sn + v * cs, 15);
    end else if (!d_on_a) begin
      o[0] = round_shift(u * sn + v * cs, 15);
      o[1] = round_shift(-u * cs + v * sn, 15);
    end else begin
      o[0] = round_shift(u * cs - v * sn, 15);
      o[1] = round_shift(u * sn + v * cs, 15);
    end
    o[2] = ze;
  endfunction

  function automatic xform_res_t predict_xform(xform_req_t r);
    longint     mid[3], fin[3];
    longint     x, y, z;
    xform_res_t e;
    x = longint'(r.x);
    y = longint'(r.y);
    z = longint'(r.z);
    fin = '{0, 0, 0};
    case (r.mode)
      MODE_ABC_TO_AB0: to_ab0(x, y, z, fin);
      MODE_AB0_TO_ABC: to_abc(x, y, z, fin);
      MODE_AB0_TO_DQ0: rotate(0, x, y, z, r.angle, fin);
      MODE_DQ0_TO_AB0: rotate(1, x, y, z, r.angle, fin);
      MODE_ABC_TO_DQ0: begin
        to_ab0(x, y, z, mid);
        rotate(0, mid[0], mid[1], mid[2], r.angle, fin);
      end
      MODE_DQ0_TO_ABC: begin
        rotate(1, x, y, z, r.angle, mid);
        to_abc(mid[0], mid[1], mid[2], fin);
      end
      default: fin = '{0, 0, 0};
    endcase
    e.sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (fin[j] > 32767) begin
        fin[j] = 32767;
        e.sat  = 1'b1;
      end
      if (fin[j] < -32768) begin
        fin[j] = -32768;
        e.sat  = 1'b1;
      end
    end
    e.x = SAMPLE_W'(fin[0]);
    e.y = SAMPLE_W'(fin[1]);
    e.z = SAMPLE_W'(fin[2]);
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Present one transaction after an optional idle gap; hold until accepted.
  task automatic send_xform(xform_req_t r, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= r.mode;
    in_ch.in_x  <= r.x;
    in_ch.in_y  <= r.y;
    in_ch.in_z  <= r.z;
    in_ch.angle <= r.angle;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note(predict_xform(r));
  endtask

  // Drop valid, drain the pipeline, then write both registers.
  task automatic reconfigure(logic scale, logic frame);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SCALING;
    cfg_data_i <= scale;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FRAME;
    cfg_data_i <= frame;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pwr_scale_n = scale;
    d_on_a      = frame;
  endtask

  task automatic run_directed();
    xform_req_t r;
    logic [ANGLE_W-1:0] angs[5];
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    for (int m = 0; m < 6; m++) begin
      r.mode = MODE_W'(m);
      // full scale positive, full scale negative, and alternating extremes
      r.x = SAMPLE_MAX; r.y = SAMPLE_MAX; r.z = SAMPLE_MAX; r.angle = angs[m % 5];
      send_xform(r, pick_gap());
      r.x = SAMPLE_MIN; r.y = SAMPLE_MIN; r.z = SAMPLE_MIN; r.angle = angs[(m + 1) % 5];
      send_xform(r, pick_gap());
      r.x = SAMPLE_MAX; r.y = SAMPLE_MIN; r.z = SAMPLE_MAX; r.angle = angs[(m + 3) % 5];
      send_xform(r, 0);
    end
    // spare modes must return zeros
    r.x = SAMPLE_MAX; r.y = SAMPLE_MIN; r.z = 16'sd1234; r.angle = 16'hFFFF;
    r.mode = MODE_SPARE_6;
    send_xform(r, 0);
    r.mode = MODE_SPARE_7;
    send_xform(r, 1);
    // zero input at an odd angle
    r.mode = MODE_ABC_TO_DQ0; r.x = '0; r.y = '0; r.z = '0; r.angle = 16'h2AAA;
    send_xform(r, 0);
  endtask

  task automatic run_random(int count);
    xform_req_t r;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      r.mode  = (sel < 18) ? MODE_W'(sel % 6) : ((sel == 18) ? MODE_SPARE_6 : MODE_SPARE_7);
      r.x     = pick_sample();
      r.y     = pick_sample();
      r.z     = pick_sample();
      r.angle = ANGLE_W'($urandom);
      send_xform(r, pick_gap());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and checking
  // ---------------------------------------------------------------------------

  initial begin
    int run;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      run = pick_gap();
      if (run > 0) begin
        out_ch.ready <= 1'b0;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    xform_res_t a;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      a.x   = out_ch.out_x;
      a.y   = out_ch.out_y;
      a.z   = out_ch.out_z;
      a.sat = out_ch.saturated;
      sb.check(a);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || drain_done) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    sb = new();
    fill_sine();
    pwr_scale_n = 1'b0;
    d_on_a      = 1'b0;
    drain_done  = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_SCALING;
    cfg_data_i  = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode  = MODE_ABC_TO_AB0;
    in_ch.in_x  = '0;
    in_ch.in_y  = '0;
    in_ch.in_z  = '0;
    in_ch.angle = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, then walk every combination, ending back at reset values.
    run_directed();
    run_random(RAND_ITEMS);
    reconfigure(1'b1, 1'b0);
    run_directed();
    run_random(RAND_ITEMS);
    reconfigure(1'b1, 1'b1);
    run_directed();
    run_random(RAND_ITEMS);
    reconfigure(1'b0, 1'b1);
    run_directed();
    run_random(RAND_ITEMS);
    reconfigure(1'b0, 1'b0);
    run_random(RAND_ITEMS / 4);

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    drain_done = 1;
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
